// ===== design/lfbc_pkg.sv =====
package lfbc_pkg;

  localparam int unsigned MAX_PAYLOAD = 8;
  localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 4;

  // Result word layout, lowest bit first.
  localparam int unsigned OUT_ID_LSB   = 0;
  localparam int unsigned OUT_LEN_LSB  = OUT_ID_LSB + BYTE_W;
  localparam int unsigned OUT_DATA_LSB = OUT_LEN_LSB + LEN_W;
  localparam int unsigned OUT_CS_LSB   = OUT_DATA_LSB + MAX_PAYLOAD * BYTE_W;
  localparam int unsigned OUT_USED_W   = OUT_CS_LSB + BYTE_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [7:0] ID_FIELD_MASK = 8'h3F;
  localparam logic [7:0] ID_SHORT_MAX  = 8'h1F;
  localparam logic [7:0] ID_MID_MAX    = 8'h2F;
  localparam logic [7:0] CS_INVERT     = 8'hFF;

  localparam logic [LEN_W-1:0] LEN_SHORT = 4'd2;
  localparam logic [LEN_W-1:0] LEN_MID   = 4'd4;
  localparam logic [LEN_W-1:0] LEN_LONG  = 4'd8;

  localparam logic CS_CLASSIC  = 1'b0;
  localparam logic CS_ENHANCED = 1'b1;

  localparam logic PH_ID   = 1'b0;
  localparam logic PH_DATA = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  function automatic logic [LEN_W-1:0] len_of_id(input byte_t id);
    byte_t v;
    v = id & ID_FIELD_MASK;
    if (v <= ID_SHORT_MAX) begin
      return LEN_SHORT;
    end else if (v <= ID_MID_MAX) begin
      return LEN_MID;
    end
    return LEN_LONG;
  endfunction

  // Ones-complement style add: the carry out of bit 7 wraps back into bit 0.
  function automatic byte_t carry_add(input byte_t a, input byte_t b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_W-1:0] + {{(BYTE_W-1){1'b0}}, s[BYTE_W]};
  endfunction

endpackage

// ===== design/lin_frame_byte_collector_core.sv =====
// LIN frame byte collector.
// Input stream: one received byte per word on in_tdata. The first byte of a
// frame is the protected identifier; its low six bits select 2, 4 or 8
// payload bytes, which follow as further words.
// Output stream: one word per completed frame, carrying the identifier, the
// payload length, eight payload slots (unused slots zero) and the inverted
// carry-wrapped checksum.
// Configuration: an APB-style port with one register at addresses 0 to 3
// (cfg_paddr[2] clear), checksum_mode (0 classic, 1 enhanced with
// identifier). The mode is sampled when the identifier arrives.
// Throughput is one byte per cycle while in_tready is high. The result
// word appears on out_tvalid in the cycle after the last payload byte
// is accepted, from a single output register fed by the running-sum
// and byte-slot logic. A stalled receiver holds the result word; input
// is still taken in that time unless the byte would complete another
// frame, in which case in_tready drops until the held word is taken.
// Synchronous reset returns the frame phase to waiting for an identifier,
// empties the output register and sets checksum_mode to enhanced.
module lin_frame_byte_collector_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] frame_id, [11:8] payload_len, [19:12] byte0 ... [75:68] byte7,
  // [83:76] frame_checksum, [87:84] zero
  output logic [lfbc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [2:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  logic                                  mode_r;
  logic                                  phase_r, phase_nxt;
  lfbc_pkg::byte_t                       id_r, id_nxt;
  logic [lfbc_pkg::LEN_W-1:0]            len_r, len_nxt;
  logic [lfbc_pkg::LEN_W-1:0]            cnt_r, cnt_nxt;
  lfbc_pkg::byte_t                       sum_r, sum_nxt;
  lfbc_pkg::byte_t                       store_r   [lfbc_pkg::MAX_PAYLOAD];
  lfbc_pkg::byte_t                       store_nxt [lfbc_pkg::MAX_PAYLOAD];
  logic                                  out_valid_r, out_valid_nxt;
  logic [lfbc_pkg::OUT_TDATA_W-1:0]      out_data_r, out_data_nxt;
  logic                                  in_acc;
  logic                                  frame_done;
  logic                                  cfg_wr;
  logic                                  done_pending;

  // Config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lfbc_pkg::CS_ENHANCED;
    end else if (cfg_wr) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  // Only a byte that completes a frame needs the output register free.
  assign done_pending = (phase_r == lfbc_pkg::PH_DATA) &&
                        ((cnt_r + 4'd1) >= len_r);
  assign in_tready    = !out_valid_r || out_tready || !done_pending;
  assign in_acc       = in_tvalid && in_tready;

  always_comb begin
    phase_nxt  = phase_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    frame_done = 1'b0;
    for (int i = 0; i < lfbc_pkg::MAX_PAYLOAD; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (in_acc) begin
      if (phase_r == lfbc_pkg::PH_ID) begin
        id_nxt    = in_tdata;
        len_nxt   = lfbc_pkg::len_of_id(in_tdata);
        cnt_nxt   = '0;
        sum_nxt   = (mode_r == lfbc_pkg::CS_ENHANCED) ? in_tdata : 8'd0;
        phase_nxt = lfbc_pkg::PH_DATA;
        for (int i = 0; i < lfbc_pkg::MAX_PAYLOAD; i++) begin
          store_nxt[i] = '0;
        end
      end else begin
        store_nxt[cnt_r[lfbc_pkg::IDX_W-1:0]] = in_tdata;
        cnt_nxt = cnt_r + 4'd1;
        sum_nxt = lfbc_pkg::carry_add(sum_r, in_tdata);
        if (cnt_nxt >= len_r) begin
          frame_done = 1'b1;
          phase_nxt  = lfbc_pkg::PH_ID;
          cnt_nxt    = '0;
        end
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[lfbc_pkg::OUT_ID_LSB +: lfbc_pkg::BYTE_W] = id_r;
    out_data_nxt[lfbc_pkg::OUT_LEN_LSB +: lfbc_pkg::LEN_W] = len_r;
    for (int i = 0; i < lfbc_pkg::MAX_PAYLOAD; i++) begin
      out_data_nxt[lfbc_pkg::OUT_DATA_LSB + i * lfbc_pkg::BYTE_W +: lfbc_pkg::BYTE_W] =
        store_nxt[i];
    end
    out_data_nxt[lfbc_pkg::OUT_CS_LSB +: lfbc_pkg::BYTE_W] = sum_nxt ^ lfbc_pkg::CS_INVERT;
  end

  always_comb begin
    if (frame_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lfbc_pkg::PH_ID;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    len_r <= len_nxt;
    cnt_r <= cnt_nxt;
    sum_r <= sum_nxt;
    for (int i = 0; i < lfbc_pkg::MAX_PAYLOAD; i++) begin
      store_r[i] <= store_nxt[i];
    end
    if (frame_done) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/lfbc_checker.sv =====
module lfbc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lfbc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [lfbc_pkg::LEN_W-1:0] len_w;
  assign len_w = out_tdata[lfbc_pkg::OUT_LEN_LSB +: lfbc_pkg::LEN_W];

  // A held result word must not change or vanish while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Every result carries a legal length and zero padding.
  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((len_w == lfbc_pkg::LEN_SHORT) || (len_w == lfbc_pkg::LEN_MID) ||
                    (len_w == lfbc_pkg::LEN_LONG)) &&
                   (out_tdata[lfbc_pkg::OUT_TDATA_W-1:lfbc_pkg::OUT_USED_W] == '0))
    else $error("illegal payload length or padding");

  // A fresh result word needs a byte accepted in the cycle before.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !($past(out_tvalid) && !$past(out_tready))
      |-> $past(in_tvalid && in_tready))
    else $error("result word without an accepted byte");

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // With the output side free, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

endmodule

bind lin_frame_byte_collector_core lfbc_checker u_lfbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
